>>> rtl/core/css_tok_pkg.sv
// ----------------------------------------------------------------------------
// css_tok_pkg
// Shared types and constants of the stylesheet rule tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package css_tok_pkg;

  // Byte budget of the downstream selector and declaration buffers.
  localparam int BUFFER_CAPACITY = 1024;
  // Saturation point of the brace depth counters.
  localparam int NEST_LIMIT      = 255;

  localparam int SEL_W   = 12;
  localparam int DECL_W  = 11;
  localparam int DEPTH_W = 8;

  localparam logic [SEL_W-1:0]   SEL_LIMIT_RST = 12'd1024;
  localparam logic [SEL_W-1:0]   SEL_COUNT_MAX = 12'd4095;
  localparam logic [SEL_W-1:0]   SEL_EMIT_MAX  = SEL_W'(BUFFER_CAPACITY - 1);
  localparam int                 DECL_CAP_INT  =
      (BUFFER_CAPACITY - 1 > 2047) ? 2047 : BUFFER_CAPACITY - 1;
  localparam logic [DECL_W-1:0]  DECL_CAP      = DECL_W'(DECL_CAP_INT);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX     = DEPTH_W'(NEST_LIMIT);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [2:0] {
    EV_SEL_BYTE  = 3'd0,
    EV_RULE_OPEN = 3'd1,
    EV_DECL_BYTE = 3'd2,
    EV_DECL_END  = 3'd3,
    EV_RULE_END  = 3'd4
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   event_kind;
    logic [7:0] event_byte;
    logic       decl_flush;
    logic       rule_skipped;
    logic       last;
  } ev_t;

  typedef struct packed {
    logic                comment_active;
    logic                slash_pending;
    logic                star_seen;
    logic                at_rule_active;
    logic [DEPTH_W-1:0]  at_rule_depth;
    logic [DEPTH_W-1:0]  body_depth;
    logic                rule_skip;
    logic [SEL_W-1:0]    selector_length;
    logic [DECL_W-1:0]   declaration_length;
  } tok_state_t;

  // Events produced by one request: at most two, packed from slot 0.
  typedef struct packed {
    logic ev0_vld;
    ev_t  ev0;
    logic ev1_vld;
    ev_t  ev1;
  } ev_pair_t;

endpackage

`default_nettype wire

>>> rtl/core/css_tok_ifs.sv
// ----------------------------------------------------------------------------
// css_tok_ifs
// Valid/ready channels of the tokenizer: byte input and event output.
// ----------------------------------------------------------------------------
`default_nettype none

interface css_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface css_tok_ev_if;
  import css_tok_pkg::*;
  logic       valid;
  logic       ready;
  ev_kind_e   event_kind;
  logic [7:0] event_byte;
  logic       decl_flush;
  logic       rule_skipped;
  logic       last;

  modport source (output valid, output event_kind, output event_byte,
                  output decl_flush, output rule_skipped, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input event_byte,
                  input decl_flush, input rule_skipped, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/css_tok_step.sv
// ----------------------------------------------------------------------------
// css_tok_step
// Tokenizer state register and the per-byte update: comment stripping,
// slash hold-back, at-rule skipping and rule body tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module css_tok_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [7:0]                    byte_i,
  input  wire logic                          eos_i,
  input  wire logic [css_tok_pkg::SEL_W-1:0] sel_limit_i,
  output      css_tok_pkg::ev_pair_t         evs_o
);
  import css_tok_pkg::*;

  typedef struct packed {
    tok_state_t st;
    logic       vld;
    ev_t        ev;
  } hres_t;

  function automatic hres_t handle(tok_state_t s, logic [7:0] c,
                                   logic [SEL_W-1:0] lim);
    hres_t             r;
    logic [DEPTH_W-1:0] nd;
    r     = '0;
    r.st  = s;
    if (s.at_rule_active) begin
      if (c == CH_LBRACE) begin
        if (s.at_rule_depth < DEPTH_MAX) r.st.at_rule_depth = s.at_rule_depth + 1'b1;
      end else if (c == CH_RBRACE) begin
        nd = (s.at_rule_depth != '0) ? s.at_rule_depth - 1'b1 : '0;
        r.st.at_rule_depth = nd;
        if (nd == '0) r.st.at_rule_active = 1'b0;
      end else if (c == CH_SEMI && s.at_rule_depth == '0) begin
        r.st.at_rule_active = 1'b0;
      end
    end else if (s.body_depth == '0) begin
      if (s.selector_length == '0 && (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C})) begin
        // drop leading whitespace
      end else if (c == CH_AT && s.selector_length == '0) begin
        r.st.at_rule_active = 1'b1;
        r.st.at_rule_depth  = '0;
      end else if (c == CH_LBRACE) begin
        r.st.body_depth         = DEPTH_W'(1);
        r.st.declaration_length = '0;
        r.st.rule_skip          = (s.selector_length > lim);
        r.vld                   = 1'b1;
        r.ev.event_kind         = EV_RULE_OPEN;
      end else begin
        if (s.selector_length < SEL_EMIT_MAX) begin
          r.vld           = 1'b1;
          r.ev.event_kind = EV_SEL_BYTE;
          r.ev.event_byte = c;
        end
        if (s.selector_length < SEL_COUNT_MAX)
          r.st.selector_length = s.selector_length + 1'b1;
      end
    end else begin
      if (c == CH_LBRACE) begin
        if (s.body_depth < DEPTH_MAX) r.st.body_depth = s.body_depth + 1'b1;
      end else if (c == CH_RBRACE) begin
        r.st.body_depth = s.body_depth - 1'b1;
        if (s.body_depth == DEPTH_W'(1)) begin
          r.vld                   = 1'b1;
          r.ev.event_kind         = EV_RULE_END;
          r.ev.decl_flush         = !s.rule_skip && (s.declaration_length != '0);
          r.ev.rule_skipped       = s.rule_skip;
          r.st.selector_length    = '0;
          r.st.declaration_length = '0;
          r.st.rule_skip          = 1'b0;
        end
      end else if (s.body_depth > DEPTH_W'(1) || s.rule_skip) begin
        // nested block or skipped rule: ignore
      end else if (c == CH_SEMI) begin
        if (s.declaration_length != '0) begin
          r.vld                   = 1'b1;
          r.ev.event_kind         = EV_DECL_END;
          r.st.declaration_length = '0;
        end
      end else if (s.declaration_length < DECL_CAP) begin
        r.vld                   = 1'b1;
        r.ev.event_kind         = EV_DECL_BYTE;
        r.ev.event_byte         = c;
        r.st.declaration_length = s.declaration_length + 1'b1;
      end
    end
    return r;
  endfunction

  tok_state_t state_q, state_d;
  hres_t      h_slash, h_byte;
  tok_state_t s_mid;
  logic       use_slash, use_byte;

  always_comb begin
    s_mid     = state_q;
    use_slash = 1'b0;
    use_byte  = 1'b0;
    h_byte    = '0;
    state_d   = state_q;

    if (!state_q.comment_active && state_q.slash_pending && !(eos_i == 1'b0 && byte_i == CH_STAR))
      use_slash = 1'b1;
    s_mid.slash_pending = 1'b0;
    h_slash = handle(s_mid, CH_SLASH, sel_limit_i);

    if (eos_i) begin
      state_d = '0;
    end else if (state_q.comment_active) begin
      if (state_q.star_seen && byte_i == CH_SLASH) begin
        state_d.comment_active = 1'b0;
        state_d.star_seen      = 1'b0;
      end else begin
        state_d.star_seen = (byte_i == CH_STAR);
      end
    end else if (state_q.slash_pending && byte_i == CH_STAR) begin
      // slash-star opens a comment
      state_d                = s_mid;
      state_d.comment_active = 1'b1;
      state_d.star_seen      = 1'b0;
    end else begin
      state_d = use_slash ? h_slash.st : state_q;
      if (byte_i == CH_SLASH) begin
        state_d.slash_pending = 1'b1;
      end else begin
        h_byte   = handle(state_d, byte_i, sel_limit_i);
        use_byte = 1'b1;
        state_d  = h_byte.st;
      end
    end
  end

  // pack the produced events from slot 0 and mark the final one
  always_comb begin
    logic sv, bv;
    sv    = use_slash && h_slash.vld;
    bv    = use_byte && h_byte.vld;
    evs_o = '0;
    if (sv) begin
      evs_o.ev0_vld  = 1'b1;
      evs_o.ev0      = h_slash.ev;
      evs_o.ev0.last = !bv;
      if (bv) begin
        evs_o.ev1_vld  = 1'b1;
        evs_o.ev1      = h_byte.ev;
        evs_o.ev1.last = 1'b1;
      end
    end else if (bv) begin
      evs_o.ev0_vld  = 1'b1;
      evs_o.ev0      = h_byte.ev;
      evs_o.ev0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (go_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/css_tok_evq.sv
// ----------------------------------------------------------------------------
// css_tok_evq
// Four-entry event queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module css_tok_evq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire css_tok_pkg::ev_pair_t evs_i,
  input  wire logic                  pop_i,
  output      css_tok_pkg::ev_t      head_o,
  output      logic                  nonempty_o,
  output      logic                  room2_o
);
  import css_tok_pkg::*;

  ev_t        mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] n_push;
  logic       do_pop;

  assign do_pop     = pop_i && (cnt_q != 3'd0);
  assign n_push     = push_i ? ({1'b0, evs_i.ev0_vld} + {1'b0, evs_i.ev1_vld}) : 2'd0;
  assign head_o     = mem_q[rp_q];
  assign nonempty_o = (cnt_q != 3'd0);
  assign room2_o    = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (push_i && evs_i.ev0_vld) mem_q[wp_q] <= evs_i.ev0;
    if (push_i && evs_i.ev1_vld) mem_q[wp_q + 2'd1] <= evs_i.ev1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_push;
      rp_q  <= rp_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, do_pop};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/css_rule_tokenizer_core.sv
// ----------------------------------------------------------------------------
// css_rule_tokenizer_core
// Byte-serial stylesheet tokenizer: strips comments, skips at-rules and
// emits selector, rule and declaration events.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   in_byte, end_of_stream
//   ev_o     out  valid/ready   event_kind, event_byte, decl_flush,
//                               rule_skipped, last
//   cfg      in   cfg_we_i      cfg_data_i -> selector limit
//
// One byte a cycle while the queue has room: a request waits in the input
// register, the tokenizer state updates as it leaves, and its 0 to 2 events
// (two only if a byte releases a held slash) go into a four-entry queue,
// which drains one event a cycle while ev_o is ready. Reset clears all state
// but the input byte and queue entries; the selector limit returns to 1024.
// A stalled output holds the input register once under two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module css_rule_tokenizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  css_tok_in_if.sink                         in_i,
  css_tok_ev_if.source                       ev_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [css_tok_pkg::SEL_W-1:0] cfg_data_i
);
  import css_tok_pkg::*;

  logic [SEL_W-1:0] sel_limit_q;
  logic             stg_vld_q;
  logic [7:0]       stg_byte_q;
  logic             stg_eos_q;
  logic             stg_go, room2, nonempty;
  ev_pair_t         evs;
  ev_t              head;

  assign stg_go   = stg_vld_q && room2;
  assign in_i.ready = !stg_vld_q || stg_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_limit_q <= SEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      sel_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stg_byte_q <= in_i.in_byte;
      stg_eos_q  <= in_i.end_of_stream;
    end
  end

  css_tok_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (stg_go),
    .byte_i      (stg_byte_q),
    .eos_i       (stg_eos_q),
    .sel_limit_i (sel_limit_q),
    .evs_o       (evs)
  );

  css_tok_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (stg_go),
    .evs_i      (evs),
    .pop_i      (ev_o.ready),
    .head_o     (head),
    .nonempty_o (nonempty),
    .room2_o    (room2)
  );

  assign ev_o.valid        = nonempty;
  assign ev_o.event_kind   = head.event_kind;
  assign ev_o.event_byte   = head.event_byte;
  assign ev_o.decl_flush   = head.decl_flush;
  assign ev_o.rule_skipped = head.rule_skipped;
  assign ev_o.last         = head.last;

endmodule

`default_nettype wire

>>> rtl/core/css_tok_chk.sv
// ----------------------------------------------------------------------------
// css_tok_chk
// Port-level checks of the tokenizer event stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module css_tok_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire css_tok_pkg::ev_kind_e kind_i,
  input wire logic [7:0]            byte_i,
  input wire logic                  flush_i,
  input wire logic                  skip_i,
  input wire logic                  last_i
);
  import css_tok_pkg::*;

  // only byte events carry a byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != EV_SEL_BYTE && kind_i != EV_DECL_BYTE |-> byte_i == 8'h00)
    else $error("event byte set on a non-byte event");

  a_flags_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != EV_RULE_END |-> !flush_i && !skip_i)
    else $error("rule end flags on another event");

  // a skipped rule never asks for a declaration flush
  a_flush_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(flush_i && skip_i))
    else $error("flush and skip together");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(byte_i)
                                    && $stable(last_i))
    else $error("stalled event changed");

endmodule

bind css_rule_tokenizer_core css_tok_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (ev_o.valid),
  .out_ready_i (ev_o.ready),
  .kind_i      (ev_o.event_kind),
  .byte_i      (ev_o.event_byte),
  .flush_i     (ev_o.decl_flush),
  .skip_i      (ev_o.rule_skipped),
  .last_i      (ev_o.last)
);

`default_nettype wire
